// File: rtl/core/hti_pkg.sv
// hti_pkg: shared types, constants and sizing for the heightmap height lookup
// no dependencies; used by hti_axis, heightmap_triangle_interpolation_top and hti_checker

package hti_pkg;

	// grid and coordinate mapping
	localparam int GRID_VERTS   = 64;
	localparam int TERRAIN_SIZE = 1024;
	localparam int FRAC_BITS    = 8;

	localparam int GRID_DEPTH = 4096;
	localparam int ADDR_W     = $clog2(GRID_DEPTH);
	localparam int HEIGHT_W   = 16;
	localparam int COORD_IN_W = 16;

	// in-range coordinates are 0..TERRAIN_SIZE-1, cells 0..GRID_VERTS-1
	localparam int COORD_W = $clog2(TERRAIN_SIZE);
	localparam int CELL_W  = $clog2(GRID_VERTS);
	localparam int U_W     = COORD_W + CELL_W;

	// exact floor division by TERRAIN_SIZE through a rounded-up reciprocal
	localparam int S1     = U_W + COORD_W;
	localparam int R1_W   = U_W + 2;
	localparam int P1_W   = U_W + R1_W;
	localparam logic [R1_W-1:0] R1 =
		R1_W'(((64'd1 << S1) + 64'(TERRAIN_SIZE) - 64'd1) / 64'(TERRAIN_SIZE));

	localparam int N2     = COORD_W + FRAC_BITS;
	localparam int S2     = N2 + COORD_W;
	localparam int R2_W   = N2 + 2;
	localparam int P2_W   = N2 + R2_W;
	localparam logic [R2_W-1:0] R2 =
		R2_W'(((64'd1 << S2) + 64'(TERRAIN_SIZE) - 64'd1) / 64'(TERRAIN_SIZE));

	// grid address arithmetic, wide enough for row*GRID_VERTS+column+GRID_VERTS+1
	localparam int SUM_W = (2 * CELL_W + 2 > ADDR_W) ? 2 * CELL_W + 2 : ADDR_W;

	// interpolation
	localparam int WGT_W  = FRAC_BITS + 1;
	localparam int PROD_W = FRAC_BITS + 2 + HEIGHT_W;
	localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

	// transaction kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                         kind;
		logic [ADDR_W-1:0]            load_index;
		logic signed [HEIGHT_W-1:0]   load_height;
		logic signed [COORD_IN_W-1:0] query_x;
		logic signed [COORD_IN_W-1:0] query_z;
	} req_t;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height;
		logic                       out_of_range;
	} rsp_t;

	typedef struct packed {
		logic [CELL_W-1:0] idx;
		logic              oor;
	} axis_cell_t;

endpackage

// File: rtl/core/hti_ram.sv
// hti_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies

module hti_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/hti_axis.sv
// hti_axis: maps one world coordinate to a grid cell and a cell fraction
// depends on hti_pkg; cell valid in stage 2, fraction in stage 4

module hti_axis (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [hti_pkg::COORD_IN_W-1:0] coord,
	output hti_pkg::axis_cell_t                   cell_s2,
	output logic [hti_pkg::FRAC_BITS-1:0]         frac_s4
);

	logic [hti_pkg::U_W-1:0]    u_s1, u_s2;
	logic                       bad_s1, bad_s2;
	logic [hti_pkg::CELL_W-1:0] cx_s2;
	logic [hti_pkg::N2-1:0]     n2_s3;
	logic [hti_pkg::P1_W-1:0]   prod1;
	logic [hti_pkg::P2_W-1:0]   prod2;
	logic [hti_pkg::U_W-1:0]    rem_full;
	logic                       below;

	// anything negative or at least TERRAIN_SIZE lands outside the grid
	assign below = {1'b0, coord} < (hti_pkg::COORD_IN_W + 1)'(hti_pkg::TERRAIN_SIZE);

	assign prod1    = hti_pkg::P1_W'(u_s1) * hti_pkg::P1_W'(hti_pkg::R1);
	assign rem_full = u_s2 - hti_pkg::U_W'(cx_s2) * hti_pkg::U_W'(hti_pkg::TERRAIN_SIZE);
	assign prod2    = hti_pkg::P2_W'(n2_s3) * hti_pkg::P2_W'(hti_pkg::R2);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1   <= hti_pkg::U_W'(coord[hti_pkg::COORD_W-1:0])
				* hti_pkg::U_W'(hti_pkg::GRID_VERTS);
			bad_s1 <= coord[hti_pkg::COORD_IN_W-1] || !below;
			u_s2   <= u_s1;
			bad_s2 <= bad_s1;
			cx_s2  <= prod1[hti_pkg::S1 +: hti_pkg::CELL_W];
			n2_s3  <= {rem_full[hti_pkg::COORD_W-1:0], {hti_pkg::FRAC_BITS{1'b0}}};
			frac_s4 <= prod2[hti_pkg::S2 +: hti_pkg::FRAC_BITS];
		end
	end

	// last column or row has no neighbor to interpolate with
	assign cell_s2.idx = cx_s2;
	assign cell_s2.oor = bad_s2 || (cx_s2 == hti_pkg::CELL_W'(hti_pkg::GRID_VERTS - 1));

endmodule

// File: rtl/core/heightmap_triangle_interpolation_top.sv
// heightmap_triangle_interpolation_top: grid height store and barycentric lookup
// depends on hti_pkg, hti_axis, hti_ram
// a query result passes through the s1 to s6 stage registers and then the response register
// throughput: one transaction (load or query) per cycle; a stalled result freezes the pipe
// loads write the grid in stage 2, in order with query reads, so no forwarding is needed
// reset clears the pipeline valid flags only; grid entries are undefined until loaded

module heightmap_triangle_interpolation_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hti_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hti_pkg::rsp_t rsp
);

	localparam int F  = hti_pkg::FRAC_BITS;
	localparam int HW = hti_pkg::HEIGHT_W;
	localparam int AW = hti_pkg::ADDR_W;
	localparam int SW = hti_pkg::SUM_W;
	localparam int WW = hti_pkg::WGT_W;
	localparam int PW = hti_pkg::PROD_W;

	logic en;
	logic q_s1, q_s2, q_s3, q_s4, q_s5, q_s6;
	logic ld_s1, ld_s2;
	logic [AW-1:0] ld_index_s1, ld_index_s2;
	logic [HW-1:0] ld_height_s1, ld_height_s2;
	logic oor_s3, oor_s4, oor_s5, oor_s6;

	hti_pkg::axis_cell_t cx_s2, cz_s2;
	logic [F-1:0] fx_s4, fz_s4;

	logic [SW-1:0] base;
	logic [AW-1:0] a00, a10, a01, a11;
	logic          rd_en, wr_en;
	logic [HW-1:0] r00, r10, r01, r11;

	logic signed [HW-1:0] h00_s4, h10_s4, h01_s4, h11_s4;
	logic [WW-1:0] fsum;
	logic          lower;
	logic [WW-1:0] w0_s5, w1_s5, w2_s5;
	logic signed [HW-1:0] ha_s5, hb_s5, hc_s5;
	logic signed [PW-1:0] p0_s6, p1_s6, p2_s6;
	logic signed [PW-1:0] acc, acc_adj;

	logic          rsp_valid_q;
	hti_pkg::rsp_t rsp_q;

	// the whole pipe advances unless a finished result is waiting
	assign en        = !rsp_valid_q || rsp_ready;
	assign req_ready = en;

	hti_axis u_axis_x (
		.clk     (clk),
		.en      (en),
		.coord   (req.query_x),
		.cell_s2 (cx_s2),
		.frac_s4 (fx_s4)
	);

	hti_axis u_axis_z (
		.clk     (clk),
		.en      (en),
		.coord   (req.query_z),
		.cell_s2 (cz_s2),
		.frac_s4 (fz_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_s1  <= 1'b0;
			q_s2  <= 1'b0;
			q_s3  <= 1'b0;
			q_s4  <= 1'b0;
			q_s5  <= 1'b0;
			q_s6  <= 1'b0;
			ld_s1 <= 1'b0;
			ld_s2 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			q_s1  <= req_valid && (req.kind == hti_pkg::KIND_QUERY);
			ld_s1 <= req_valid && (req.kind == hti_pkg::KIND_LOAD);
			q_s2  <= q_s1;
			ld_s2 <= ld_s1;
			q_s3  <= q_s2;
			q_s4  <= q_s3;
			q_s5  <= q_s4;
			q_s6  <= q_s5;
			rsp_valid_q <= q_s6;
		end
	end

	// grid addresses wrap modulo the store depth
	assign base = SW'(cz_s2.idx) * SW'(hti_pkg::GRID_VERTS) + SW'(cx_s2.idx);
	assign a00  = base[AW-1:0];
	assign a10  = AW'(base + SW'(1));
	assign a01  = AW'(base + SW'(hti_pkg::GRID_VERTS));
	assign a11  = AW'(base + SW'(hti_pkg::GRID_VERTS + 1));

	assign rd_en = en && q_s2;
	assign wr_en = en && ld_s2;

	// four copies of the grid so all corners come out in one read
	hti_ram #(.WIDTH(HW), .DEPTH(hti_pkg::GRID_DEPTH)) u_ram_00 (
		.clk(clk), .we(wr_en), .waddr(ld_index_s2), .wdata(ld_height_s2),
		.re(rd_en), .raddr(a00), .rdata(r00)
	);
	hti_ram #(.WIDTH(HW), .DEPTH(hti_pkg::GRID_DEPTH)) u_ram_10 (
		.clk(clk), .we(wr_en), .waddr(ld_index_s2), .wdata(ld_height_s2),
		.re(rd_en), .raddr(a10), .rdata(r10)
	);
	hti_ram #(.WIDTH(HW), .DEPTH(hti_pkg::GRID_DEPTH)) u_ram_01 (
		.clk(clk), .we(wr_en), .waddr(ld_index_s2), .wdata(ld_height_s2),
		.re(rd_en), .raddr(a01), .rdata(r01)
	);
	hti_ram #(.WIDTH(HW), .DEPTH(hti_pkg::GRID_DEPTH)) u_ram_11 (
		.clk(clk), .we(wr_en), .waddr(ld_index_s2), .wdata(ld_height_s2),
		.re(rd_en), .raddr(a11), .rdata(r11)
	);

	// triangle select and barycentric weights
	assign fsum  = WW'(fx_s4) + WW'(fz_s4);
	assign lower = fsum < hti_pkg::ONE;

	always_ff @(posedge clk) begin
		if (en) begin
			ld_index_s1  <= req.load_index;
			ld_height_s1 <= req.load_height;
			ld_index_s2  <= ld_index_s1;
			ld_height_s2 <= ld_height_s1;

			oor_s3 <= cx_s2.oor || cz_s2.oor;
			oor_s4 <= oor_s3;
			oor_s5 <= oor_s4;
			oor_s6 <= oor_s5;

			h00_s4 <= r00;
			h10_s4 <= r10;
			h01_s4 <= r01;
			h11_s4 <= r11;

			if (lower) begin
				w0_s5 <= hti_pkg::ONE - fsum;
				ha_s5 <= h00_s4;
				w1_s5 <= WW'(fx_s4);
				hb_s5 <= h10_s4;
				w2_s5 <= WW'(fz_s4);
			end else begin
				w0_s5 <= hti_pkg::ONE - WW'(fz_s4);
				ha_s5 <= h10_s4;
				w1_s5 <= fsum - hti_pkg::ONE;
				hb_s5 <= h11_s4;
				w2_s5 <= hti_pkg::ONE - WW'(fx_s4);
			end
			hc_s5 <= h01_s4;

			p0_s6 <= $signed({1'b0, w0_s5}) * ha_s5;
			p1_s6 <= $signed({1'b0, w1_s5}) * hb_s5;
			p2_s6 <= $signed({1'b0, w2_s5}) * hc_s5;
		end
	end

	// divide by ONE, truncating toward zero
	assign acc     = p0_s6 + p1_s6 + p2_s6;
	assign acc_adj = acc + (acc[PW-1] ? PW'((1 << F) - 1) : PW'(0));

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.height       <= oor_s6 ? HW'(0) : acc_adj[F +: HW];
			rsp_q.out_of_range <= oor_s6;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/core/hti_checker.sv
// hti_checker: port-level checks for the heightmap lookup top level
// depends on hti_pkg; bound to heightmap_triangle_interpolation_top below

module hti_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input hti_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input hti_pkg::rsp_t rsp
);

	// a waiting request holds still
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while waiting");

	// a waiting result holds still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// out of range results always read as zero height
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_of_range |-> rsp.height == '0)
		else $error("out of range result with nonzero height");

	// a stalled result blocks new transactions
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while result stalled");

	// an empty output never blocks the input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input not ready with empty output");

endmodule

bind heightmap_triangle_interpolation_top hti_checker u_hti_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
